// ----- hdl/bfn_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the box face neighbor finder
package bfn_pkg;

  localparam int MaxBoxesDef = 64;
  localparam int CoordW      = 24;
  localparam int IndexW      = 6;
  localparam int CountW      = 7;
  localparam int AddrW       = 3;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic RegBoxCount = 1'b0;

  typedef struct packed {
    logic [2:0][CoordW-1:0] lo;
    logic [2:0][CoordW-1:0] hi;
  } box_t;

  typedef struct packed {
    logic [2:0] face;
    box_t       self_box;
  } query_t;

endpackage

// ----- hdl/bfn_cell.sv -----
`timescale 1ns / 1ps
// one table cell: stores a box and tests it against the query as the token passes
module bfn_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  bfn_pkg::box_t wr_box_i,
  input  bfn_pkg::query_t query_i,
  input  logic          tok_i,
  output logic          tok_o,
  output logic          hit_o,
  output bfn_pkg::box_t box_o
);
  import bfn_pkg::*;

  box_t box_q;
  logic tok_q;
  logic [2:0] meet;
  logic [2:0] slab;
  logic [2:0] ok;
  logic [1:0] ax;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      box_q <= wr_box_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_comb begin
    logic signed [CoordW:0] olo, ohi, slo, shi;
    ax = query_i.face[2:1];
    for (int a = 0; a < 3; a++) begin
      olo = {box_q.lo[a][CoordW-1], box_q.lo[a]};
      ohi = {box_q.hi[a][CoordW-1], box_q.hi[a]};
      slo = {query_i.self_box.lo[a][CoordW-1], query_i.self_box.lo[a]};
      shi = {query_i.self_box.hi[a][CoordW-1], query_i.self_box.hi[a]};
      meet[a] = !((ohi < slo) || (shi < olo));
      if (query_i.face[0]) begin
        slab[a] = (olo == shi + (CoordW+1)'(1));
      end else begin
        slab[a] = (ohi + (CoordW+1)'(1) == slo);
      end
      ok[a] = (32'(ax) == a) ? slab[a] : meet[a];
    end
  end

  assign hit_o = tok_i && (query_i.face < 3'd6) && (&ok);
  assign tok_o = tok_q;
  assign box_o = box_q;

endmodule

// ----- hdl/box_face_neighbor_finder.sv -----
`timescale 1ns / 1ps
// top level of the box face neighbor finder
// usage:
//   an item is taken when start is high and busy is low. operation 0 writes
//   box box_index into the table and gives no result. operation 1 queries
//   the neighbors of box_index on the given face. a query fetches the
//   queried box, then a token walks the row of cells, one cell (one stored
//   box) per cycle, then the closing beat is sent. an out-of-range index
//   skips the walk. each neighbor gives one result beat, marked by strobe_o
//   for one cycle, in ascending index order; the final beat has last_o set.
//   an out-of-range index or no neighbor gives a single beat with found_o
//   low. busy drops in the cycle that carries the closing beat, so the next
//   item can be taken at the edge that ends it. box_count is set through the
//   apb port at address 0; the user must write it only while idle, which
//   the block itself does not enforce. reset clears box_count and the
//   control state; table contents stay undefined until written. the
//   receiver cannot stall result beats.
module box_face_neighbor_finder #(
  parameter int MAX_BOXES = bfn_pkg::MaxBoxesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bfn_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation_i,
  input  logic [bfn_pkg::IndexW-1:0] box_index_i,
  input  logic [bfn_pkg::CoordW-1:0] lo_x_i,
  input  logic [bfn_pkg::CoordW-1:0] lo_y_i,
  input  logic [bfn_pkg::CoordW-1:0] lo_z_i,
  input  logic [bfn_pkg::CoordW-1:0] hi_x_i,
  input  logic [bfn_pkg::CoordW-1:0] hi_y_i,
  input  logic [bfn_pkg::CoordW-1:0] hi_z_i,
  input  logic [2:0]                 face_i,
  output logic                       strobe_o,
  output logic [bfn_pkg::IndexW-1:0] neighbor_index_o,
  output logic                       found_o,
  output logic                       last_o
);
  import bfn_pkg::*;

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = (IW + 1 > CountW) ? IW + 1 : CountW;
  localparam logic [CW-1:0] MaxC = CW'(MAX_BOXES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] box_count_q;
  logic [IndexW-1:0] qidx_q;
  logic [2:0]        face_q;
  box_t              self_q;
  logic              tok0_q, tok0_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [IndexW-1:0] pend_idx_q, pend_idx_d;
  logic              strobe_q, strobe_d;
  logic [IndexW-1:0] nidx_q, nidx_d;
  logic              found_q, found_d;
  logic              last_q, last_d;

  logic [CW-1:0] used, cnt_ext, qidx_ext;
  logic          take, wr_en, hit_now;
  box_t          wr_box;
  query_t        query;
  logic [MAX_BOXES:0]   tok;
  logic [MAX_BOXES-1:0] hits;
  box_t                 boxes [MAX_BOXES];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegBoxCount) ? 32'(box_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_count_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == RegBoxCount)) begin
      box_count_q <= pwdata[CountW-1:0];
    end
  end

  assign busy  = (state_q != S_IDLE);
  assign take  = start && !busy;
  assign wr_en = take && (operation_i == OpWrite);

  assign wr_box.lo = {lo_z_i, lo_y_i, lo_x_i};
  assign wr_box.hi = {hi_z_i, hi_y_i, hi_x_i};
  assign query.face = face_q;
  assign query.self_box = self_q;

  assign used     = (CW'(box_count_q) > MaxC) ? MaxC : CW'(box_count_q);
  assign cnt_ext  = CW'(cnt_q);
  assign qidx_ext = CW'(qidx_q);

  assign tok[0] = tok0_q;

  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    bfn_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en && (CW'(box_index_i) == CW'(g))),
      .wr_box_i (wr_box),
      .query_i  (query),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .hit_o    (hits[g]),
      .box_o    (boxes[g])
    );
  end

  assign hit_now = (|hits) && (cnt_ext < used) && (cnt_ext != qidx_ext);

  always_comb begin
    state_d    = state_q;
    tok0_d     = 1'b0;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    strobe_d   = 1'b0;
    nidx_d     = nidx_q;
    found_d    = found_q;
    last_d     = last_q;
    case (state_q)
      S_IDLE: begin
        if (take && (operation_i == OpQuery)) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        pend_d = 1'b0;
        cnt_d  = '0;
        if (qidx_ext >= used) begin
          state_d = S_DONE;
        end else begin
          tok0_d  = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          if (pend_q) begin
            strobe_d = 1'b1;
            nidx_d   = pend_idx_q;
            found_d  = 1'b1;
            last_d   = 1'b0;
          end
          pend_d     = 1'b1;
          pend_idx_d = cnt_ext[IndexW-1:0];
        end
        if (cnt_ext == MaxC - CW'(1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      S_DONE: begin
        strobe_d = 1'b1;
        nidx_d   = pend_q ? pend_idx_q : '0;
        found_d  = pend_q;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tok0_q   <= 1'b0;
      strobe_q <= 1'b0;
      pend_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      tok0_q   <= tok0_d;
      strobe_q <= strobe_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    nidx_q     <= nidx_d;
    found_q    <= found_d;
    last_q     <= last_d;
    if (take && (operation_i == OpQuery)) begin
      qidx_q <= box_index_i;
      face_q <= face_i;
    end
    if (state_q == S_LOAD) begin
      self_q <= boxes[qidx_ext[IW-1:0]];
    end
  end

  assign strobe_o         = strobe_q;
  assign neighbor_index_o = nidx_q;
  assign found_o          = found_q;
  assign last_o           = last_q;

endmodule

// ----- tb/bfn_checker.sv -----
`timescale 1ns / 1ps
// checker: tracks box_count and the box table, predicts neighbor beats and compares them
module bfn_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bfn_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       operation_i,
  input  logic [bfn_pkg::IndexW-1:0] box_index_i,
  input  logic [bfn_pkg::CoordW-1:0] lo_x_i,
  input  logic [bfn_pkg::CoordW-1:0] lo_y_i,
  input  logic [bfn_pkg::CoordW-1:0] lo_z_i,
  input  logic [bfn_pkg::CoordW-1:0] hi_x_i,
  input  logic [bfn_pkg::CoordW-1:0] hi_y_i,
  input  logic [bfn_pkg::CoordW-1:0] hi_z_i,
  input  logic [2:0]                 face_i,
  input  logic                       strobe_o,
  input  logic [bfn_pkg::IndexW-1:0] neighbor_index_o,
  input  logic                       found_o,
  input  logic                       last_o,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         beats_seen_o,
  output int                         hits_seen_o
);
  import bfn_pkg::*;

  localparam int NumBoxes = MaxBoxesDef;

  typedef struct {
    logic [IndexW-1:0] neighbor_index;
    logic              found;
    logic              last;
  } beat_t;

  beat_t             beat_queue[$];
  int                box_lo[NumBoxes][3];
  int                box_hi[NumBoxes][3];
  logic [CountW-1:0] box_count_q;

  function automatic bit spans_meet(int a0, int a1, int b0, int b1);
    return !(a1 < b0 || b1 < a0);
  endfunction

  function automatic bit is_face_neighbor(int self_i, int other_i, int face);
    int ax;
    int u;
    int v;
    bit slab;
    ax = face >> 1;
    if (ax > 2) return 1'b0;
    u = (ax + 1) % 3;
    v = (ax + 2) % 3;
    if (face[0] == 1'b0) slab = (box_hi[other_i][ax] + 1 == box_lo[self_i][ax]);
    else slab = (box_lo[other_i][ax] == box_hi[self_i][ax] + 1);
    return slab &&
      spans_meet(box_lo[other_i][u], box_hi[other_i][u], box_lo[self_i][u], box_hi[self_i][u]) &&
      spans_meet(box_lo[other_i][v], box_hi[other_i][v], box_lo[self_i][v], box_hi[self_i][v]);
  endfunction

  task automatic predict_neighbors(int self_i, int face);
    int    used;
    int    n;
    beat_t b;
    used = (box_count_q > NumBoxes) ? NumBoxes : int'(box_count_q);
    n = 0;
    if (self_i < used) begin
      for (int i = 0; i < used; i++) begin
        if (i != self_i && is_face_neighbor(self_i, i, face)) begin
          b.neighbor_index = IndexW'(i);
          b.found = 1'b1;
          b.last = 1'b0;
          beat_queue = {beat_queue, b};
          n++;
        end
      end
    end
    if (n == 0) begin
      b.neighbor_index = '0;
      b.found = 1'b0;
      b.last = 1'b1;
      beat_queue = {beat_queue, b};
    end else begin
      beat_queue[beat_queue.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t exp_beat;
    if (!rst_ni) begin
      box_count_q <= '0;
      fail_count_o <= 0;
      pending_o <= 0;
      beats_seen_o <= 0;
      hits_seen_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrW'(4 * RegBoxCount)) begin
        box_count_q <= pwdata[CountW-1:0];
      end
      if (strobe_o) begin
        beats_seen_o <= beats_seen_o + 1;
        if (found_o) hits_seen_o <= hits_seen_o + 1;
        if (beat_queue.size() == 0) begin
          $error("unexpected beat: neighbor_index %0d found %0b last %0b",
                 neighbor_index_o, found_o, last_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_beat = beat_queue.pop_front();
          if (neighbor_index_o !== exp_beat.neighbor_index || found_o !== exp_beat.found ||
              last_o !== exp_beat.last) begin
            fail_count_o <= fail_count_o + 1;
          end
          if (neighbor_index_o !== exp_beat.neighbor_index)
            $error("neighbor_index expected %0d actual %0d",
                   exp_beat.neighbor_index, neighbor_index_o);
          if (found_o !== exp_beat.found)
            $error("found expected %0b actual %0b", exp_beat.found, found_o);
          if (last_o !== exp_beat.last)
            $error("last expected %0b actual %0b", exp_beat.last, last_o);
        end
      end
      if (start && !busy) begin
        if (operation_i == OpWrite) begin
          box_lo[box_index_i][0] = int'($signed(lo_x_i));
          box_lo[box_index_i][1] = int'($signed(lo_y_i));
          box_lo[box_index_i][2] = int'($signed(lo_z_i));
          box_hi[box_index_i][0] = int'($signed(hi_x_i));
          box_hi[box_index_i][1] = int'($signed(hi_y_i));
          box_hi[box_index_i][2] = int'($signed(hi_z_i));
        end else begin
          predict_neighbors(int'(box_index_i), int'(face_i));
        end
      end
      pending_o <= beat_queue.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, apb and command stimulus, watchdog and verdict
module tb_top;
  import bfn_pkg::*;

  localparam int NumBoxes = MaxBoxesDef;
  localparam int StallLimit = 1000;
  localparam int CoordMax = 8388607;
  localparam int CoordMin = -8388608;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic                operation_i;
  logic [IndexW-1:0]   box_index_i;
  logic [CoordW-1:0]   lo_x_i, lo_y_i, lo_z_i, hi_x_i, hi_y_i, hi_z_i;
  logic [2:0]          face_i;
  logic                strobe_o;
  logic [IndexW-1:0]   neighbor_index_o;
  logic                found_o;
  logic                last_o;
  int                  fail_count;
  int                  pending;
  int                  beats_seen;
  int                  hits_seen;
  int                  idle_pct;
  int                  stall_cycles;
  int                  writes_sent;
  int                  queries_sent;

  box_face_neighbor_finder i_dut (.*);

  bfn_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .start, .busy, .operation_i, .box_index_i, .lo_x_i, .lo_y_i, .lo_z_i,
    .hi_x_i, .hi_y_i, .hi_z_i, .face_i, .strobe_o, .neighbor_index_o,
    .found_o, .last_o,
    .fail_count_o(fail_count), .pending_o(pending),
    .beats_seen_o(beats_seen), .hits_seen_o(hits_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("[box_face_neighbor_finder] ERROR");
      $finish;
    end
  end

  task automatic send_item(logic op, int idx, int lx, int ly, int lz,
                           int hx, int hy, int hz, int face);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    operation_i <= op;
    box_index_i <= IndexW'(idx);
    lo_x_i <= CoordW'(lx);
    lo_y_i <= CoordW'(ly);
    lo_z_i <= CoordW'(lz);
    hi_x_i <= CoordW'(hx);
    hi_y_i <= CoordW'(hy);
    hi_z_i <= CoordW'(hz);
    face_i <= 3'(face);
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OpWrite) writes_sent++;
    else queries_sent++;
  endtask

  task automatic write_box(int idx, int lx, int ly, int lz, int hx, int hy, int hz);
    send_item(OpWrite, idx, lx, ly, lz, hx, hy, hz, 0);
  endtask

  task automatic query(int idx, int face);
    send_item(OpQuery, idx, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, face);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (NumBoxes + 8) @(posedge clk_i);
  endtask

  task automatic set_box_count(int value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * RegBoxCount);
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_write();
    int lo[3];
    int hi[3];
    int idx;
    idx = $urandom_range(NumBoxes - 1);
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(9) == 0) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        lo[a] = $urandom_range(12) - 6;
        hi[a] = lo[a] + $urandom_range(4);
        if ($urandom_range(19) == 0) hi[a] = lo[a] - 1 - $urandom_range(2);
      end
    end
    write_box(idx, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    operation_i = OpWrite;
    box_index_i = '0;
    {lo_x_i, lo_y_i, lo_z_i, hi_x_i, hi_y_i, hi_z_i} = '0;
    face_i = '0;
    stall_cycles = 0;
    idle_pct = 0;
    writes_sent = 0;
    queries_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset
    query(0, 1);
    write_box(0, 0, 0, 0, 3, 3, 3);
    write_box(1, 4, 2, 0, 6, 5, 0);
    write_box(2, -2, 0, 3, -1, 3, 9);
    write_box(3, 0, 4, 0, 0, 7, 3);
    write_box(4, 5, 1, 2, 1, -1, 0);
    write_box(5, 8388600, 0, 0, CoordMax, 3, 3);
    write_box(6, CoordMin, 0, 0, -8388600, 3, 3);
    write_box(7, 0, 0, -5, 3, 3, -1);
    for (int i = 8; i < NumBoxes; i++) random_write();
    for (int i = 8; i < NumBoxes; i++) begin
      write_box(i, $urandom_range(12) - 6, $urandom_range(12) - 6, $urandom_range(12) - 6,
                $urandom_range(8), $urandom_range(8), $urandom_range(8));
    end
    set_box_count(NumBoxes);
    for (int f = 0; f < 8; f++) query(0, f);
    query(5, 1);
    query(6, 0);
    query(4, 1);
    query(NumBoxes - 1, 3);
    set_box_count(8);
    query(10, 0);
    query(7, 5);
    set_box_count(127);
    query(0, 1);
    query(63, 4);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  set_box_count(NumBoxes); end
        1: begin idle_pct = 84; set_box_count($urandom_range(1, NumBoxes)); end
        2: begin idle_pct = 25; set_box_count(127); end
        default: begin idle_pct = 0; set_box_count(2); end
      endcase
      for (int n = 0; n < 90; n++) begin
        if (n == 45) drain();
        if ($urandom_range(99) < 40) random_write();
        else query($urandom_range(NumBoxes - 1),
                   ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5));
      end
    end
    set_box_count(0);
    query(0, 0);
    drain();

    $display("covered %0d box writes and %0d queries over several box_count settings",
             writes_sent, queries_sent);
    $display("checked %0d result beats, %0d of them neighbor hits", beats_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[box_face_neighbor_finder] OK");
    end else begin
      $display("[box_face_neighbor_finder] ERROR");
    end
    $finish;
  end

endmodule
